[rtl/jbpc_pkg.sv]
// ----------------------------------------------------------------------------
// jbpc_pkg
// Shared types and constants of the jitter buffer playout controller.
// ----------------------------------------------------------------------------
package jbpc_pkg;

  // Buffer size in packets; occupancy is carried in OCC_W bits
  localparam int unsigned BUFFER_DEPTH = 256;
  localparam int unsigned OCC_W        = 9;

  // Item kinds
  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_STOP   = 3'd1;
  localparam logic [2:0] KIND_ARRIVE = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_REPORT = 3'd4;

  // Configuration register indexes
  localparam logic [7:0] REG_MODE_SOUND = 8'd0;
  localparam logic [7:0] REG_PACKET_MS  = 8'd1;

  // Durations and limits
  localparam logic [9:0]  SOUND_DUR_MS   = 10'd20;
  localparam logic [9:0]  VIDEO_MIN_MS   = 10'd40;
  localparam logic [9:0]  PACKET_MS_INIT = 10'd40;
  localparam logic [8:0]  VIDEO_PERIODS  = 9'd150;
  localparam logic [8:0]  SOUND_PERIODS  = 9'd300;
  localparam logic [19:0] RENDER_SLACK_US = 20'd5000;
  localparam logic [15:0] OVERTIME_MAX   = 16'hFFFF;
  localparam logic [15:0] OVERTIME_ALARM = 16'd100;
  localparam logic [15:0] OVERTIME_HOLD  = 16'd10000;

  // Filter constants: estimate Q32.16, variance Q2.30
  localparam logic [47:0] EST_INIT  = 48'd20 << 16;
  localparam logic [31:0] VAR_INIT  = 32'd107374182;
  localparam logic [32:0] TWO_Q30   = 33'h0_8000_0000;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [31:0] PEAK_INIT = 32'd40;

  // Divider step counts
  localparam logic [5:0] GAIN_STEPS = 6'd30;
  localparam logic [5:0] KEEP_STEPS = 6'd32;

  // One result item
  typedef struct packed {
    logic [OCC_W-1:0] occupancy;
    logic [31:0]      jitter_ms;
    logic             slow_alarm;
    logic             play_silence;
    logic             play_head;
    logic             flush_forwarded;
    logic [OCC_W-1:0] flushed_count;
    logic             arrival_dropped;
  } result_t;

endpackage

[rtl/jitter_buffer_playout_controller.sv]
// ----------------------------------------------------------------------------
// jitter_buffer_playout_controller
// Occupancy tracker and playout decision logic for a packet jitter buffer,
// with a scalar Kalman filter on inter-arrival time.
// ----------------------------------------------------------------------------
//
//  channel  | signals                              | direction | role
//  ---------+--------------------------------------+-----------+------------------
//  s_*      | s_tvalid s_tready s_tdata s_tuser    | in        | event items
//  m_*      | m_tvalid m_tready m_tdata            | out       | one result a item
//  cfg_*    | cfg_valid cfg_ready cfg_index cfg_data | in      | register writes
//
//  Sequence: an arrival runs from accept to the next accept through the 30-step
//  restoring divide of the Kalman gain followed by four passes through the
//  shared 32x32 multiplier. A tick that flushes first runs the 32-step divide
//  of peak by duration; a plain tick runs only the multiply and compare steps.
//  s_tready is high only while the sequencer is idle.
//  Reset (rst, synchronous) restores the stopped state and register defaults.
//  The result register lets a new item in while an old result is unclaimed;
//  a finished result waits in the final step until m_tready frees the slot.
//
module jitter_buffer_playout_controller
  import jbpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] now_ms, [63:32] render_us
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [0] arrival_dropped, [9:1] flushed_count,
                                 // [10] flush_forwarded, [11] play_head,
                                 // [12] play_silence, [13] slow_alarm,
                                 // [45:14] jitter_ms, [54:46] occupancy,
                                 // [55] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_KM1    = 4'd3;
  localparam logic [3:0] S_KM2    = 4'd4;
  localparam logic [3:0] S_KM3    = 4'd5;
  localparam logic [3:0] S_KM4    = 4'd6;
  localparam logic [3:0] S_KM5    = 4'd7;
  localparam logic [3:0] S_FLUSH  = 4'd8;
  localparam logic [3:0] S_TMUL   = 4'd9;
  localparam logic [3:0] S_TCMP   = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state;
  logic [3:0] div_ret;

  // Configuration
  logic       mode_sound;
  logic [9:0] packet_ms;

  // Block state
  logic             running;
  logic [OCC_W-1:0] held;
  logic [31:0]      last_ms;
  logic [47:0]      est;
  logic [31:0]      var_q;
  logic [31:0]      peak;
  logic [8:0]       period_count;
  logic [15:0]      overtime;

  // Latched item
  logic [2:0]  kind;
  logic [31:0] now_ms;
  logic [31:0] render_us;
  logic [31:0] gap;
  logic [9:0]  dur;

  // Filter work registers
  logic [47:0] diff;
  logic        move_down;
  logic [32:0] p0;
  logic [29:0] gain;
  logic [30:0] acc;
  logic [47:0] corr;

  // Shared divider
  logic [33:0] rem;
  logic [33:0] divisor;
  logic [31:0] num;
  logic [31:0] quo;
  logic [5:0]  cnt;
  logic [34:0] div_t;
  logic [34:0] div_sub;
  logic        div_ge;

  // Shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // Result being built and result register
  result_t res;
  result_t out_q;
  logic    out_valid;

  // Decode-time helpers
  logic [9:0]  dur_cur;
  logic [47:0] meas;
  logic [19:0] render_lim;
  logic [15:0] overtime_next;
  logic [8:0]  period_lim;
  logic [30:0] gain_comp;
  logic [8:0]  keep;

  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {1'b0, out_q};

  // Packet duration from the live registers
  always_comb begin
    if (mode_sound) begin
      dur_cur = SOUND_DUR_MS;
    end else if (packet_ms < VIDEO_MIN_MS) begin
      dur_cur = VIDEO_MIN_MS;
    end else begin
      dur_cur = packet_ms;
    end
  end

  assign meas       = {gap, 16'h0000};
  assign render_lim = ({10'd0, dur} * 20'd1000) + RENDER_SLACK_US;
  assign period_lim = mode_sound ? SOUND_PERIODS : VIDEO_PERIODS;
  assign gain_comp  = ONE_Q30 - {1'b0, gain};
  assign keep       = (quo > {23'd0, held}) ? held : quo[8:0];

  // Slow-render counter: count up on overtime, down otherwise
  always_comb begin
    if ({12'd0, render_us} > {24'd0, render_lim}) begin
      overtime_next = (overtime == OVERTIME_MAX) ? overtime : overtime + 16'd1;
    end else if (overtime != 16'd0) begin
      overtime_next = overtime - 16'd1;
    end else begin
      overtime_next = overtime;
    end
  end

  // One restoring divide step
  assign div_t   = {rem, num[31]};
  assign div_sub = div_t - {1'b0, divisor};
  assign div_ge  = (div_t >= {1'b0, divisor});

  // Multiplier operand selection
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_KM1: begin
        mul_a = {2'b00, diff[29:0]};
        mul_b = {2'b00, quo[29:0]};
      end
      S_KM2: begin
        mul_a = {14'd0, diff[47:30]};
        mul_b = {2'b00, gain};
      end
      S_KM3: begin
        mul_a = {2'b00, p0[29:0]};
        mul_b = {1'b0, gain_comp};
      end
      S_KM4: begin
        mul_a = {29'd0, p0[32:30]};
        mul_b = {1'b0, gain_comp};
      end
      S_TMUL: begin
        mul_a = {23'd0, held};
        mul_b = {22'd0, dur};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sound <= 1'b0;
      packet_ms  <= PACKET_MS_INIT;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MODE_SOUND) begin
        mode_sound <= cfg_data[0];
      end else if (cfg_index == REG_PACKET_MS) begin
        packet_ms <= cfg_data[9:0];
      end
    end
  end

  // Result register: fill from the final step, drain on m_tready
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || m_tready)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || m_tready)) begin
      out_q <= {held, peak, res.slow_alarm, res.play_silence, res.play_head,
                res.flush_forwarded, res.flushed_count, res.arrival_dropped};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_ret      <= S_IDLE;
      running      <= 1'b0;
      held         <= '0;
      last_ms      <= 32'd0;
      est          <= EST_INIT;
      var_q        <= VAR_INIT;
      peak         <= PEAK_INIT;
      period_count <= 9'd0;
      overtime     <= 16'd0;
      cnt          <= 6'd0;
    end else begin
      case (state)
        S_IDLE: begin
          // latch the item and the gap since the last arrival or start
          if (s_tvalid) begin
            kind      <= s_tuser;
            now_ms    <= s_tdata[31:0];
            render_us <= s_tdata[63:32];
            gap       <= s_tdata[31:0] - last_ms;
            dur       <= dur_cur;
            res       <= '0;
            state     <= S_DECODE;
          end
        end

        S_DECODE: begin
          case (kind)
            KIND_START: begin
              if (!running) begin
                last_ms      <= now_ms;
                est          <= EST_INIT;
                var_q        <= VAR_INIT;
                peak         <= {22'd0, dur};
                period_count <= 9'd0;
                overtime     <= 16'd0;
                running      <= 1'b1;
              end
              state <= S_DONE;
            end
            KIND_STOP: begin
              running <= 1'b0;
              state   <= S_DONE;
            end
            KIND_ARRIVE: begin
              if (running) begin
                last_ms <= now_ms;
                // drop on a full buffer, but still let the timing count
                if ({23'd0, held} >= 32'(BUFFER_DEPTH)) begin
                  res.arrival_dropped <= 1'b1;
                end else begin
                  held <= held + 1'b1;
                end
                move_down <= (meas < est);
                diff      <= (meas < est) ? est - meas : meas - est;
                p0        <= {1'b0, var_q} + TWO_Q30;
                // gain = p0 * 2^30 / (p0 + 2.0): seed the remainder with p0
                rem       <= {2'b00, var_q} + {1'b0, TWO_Q30};
                divisor   <= {2'b00, var_q} + {1'b0, TWO_Q30} + {1'b0, TWO_Q30};
                num       <= 32'd0;
                quo       <= 32'd0;
                cnt       <= GAIN_STEPS;
                div_ret   <= S_KM1;
                state     <= S_DIV;
              end else begin
                state <= S_DONE;
              end
            end
            KIND_TICK: begin
              if (running) begin
                if (period_count >= period_lim) begin
                  // keep = peak / dur
                  rem     <= 34'd0;
                  divisor <= {24'd0, dur};
                  num     <= peak;
                  quo     <= 32'd0;
                  cnt     <= KEEP_STEPS;
                  div_ret <= S_FLUSH;
                  state   <= S_DIV;
                end else begin
                  state <= S_TMUL;
                end
              end else begin
                state <= S_DONE;
              end
            end
            KIND_REPORT: begin
              if (running) begin
                if (overtime_next == OVERTIME_ALARM) begin
                  overtime       <= OVERTIME_HOLD;
                  res.slow_alarm <= 1'b1;
                end else begin
                  overtime <= overtime_next;
                end
              end
              state <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end

        S_DIV: begin
          rem <= div_ge ? div_sub[33:0] : div_t[33:0];
          quo <= {quo[30:0], div_ge};
          num <= {num[30:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= div_ret;
          end
        end

        S_KM1: begin
          gain  <= quo[29:0];
          state <= S_KM2;
        end

        S_KM2: begin
          // low half of the correction
          acc   <= {1'b0, prod[59:30]};
          state <= S_KM3;
        end

        S_KM3: begin
          corr  <= 48'(prod[47:0] + {17'd0, acc});
          state <= S_KM4;
        end

        S_KM4: begin
          // move the estimate toward the measurement; truncate toward zero
          est   <= move_down ? est - corr : est + corr;
          acc   <= prod[60:30];
          state <= S_KM5;
        end

        S_KM5: begin
          var_q <= 32'(prod[33:0] + {3'd0, acc});
          if (peak < est[47:16]) begin
            peak <= est[47:16];
          end
          state <= S_DONE;
        end

        S_FLUSH: begin
          // trim the head down to what the peak interval covers
          held                <= keep;
          res.flushed_count   <= held - keep;
          res.flush_forwarded <= !mode_sound && (held != keep);
          period_count        <= 9'd0;
          peak                <= {22'd0, dur};
          state               <= S_TMUL;
        end

        S_TMUL: begin
          period_count <= period_count + 9'd1;
          state        <= S_TCMP;
        end

        S_TCMP: begin
          // release the head once the buffered time exceeds the peak
          if (held != '0 && peak < {13'd0, prod[18:0]}) begin
            held          <= held - 1'b1;
            res.play_head <= 1'b1;
          end else if (mode_sound) begin
            res.play_silence <= 1'b1;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || m_tready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
